FILE: rtl/core/huffman_data_frame_decoder_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the frame decoder
// Shared wrappers that clock and reset-qualify concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_DATA_FRAME_DECODER_TOP_DEFINES_SVH
`define HUFFMAN_DATA_FRAME_DECODER_TOP_DEFINES_SVH

// Clocked property, disabled while reset is asserted.
`define HDFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication built on the macro above.
`define HDFD_ASSERT_IMP(lbl, ante, cons, msg) \
  `HDFD_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication built on the first macro.
`define HDFD_ASSERT_NXT(lbl, ante, cons, msg) \
  `HDFD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

FILE: rtl/core/hdfd_pkg.sv
// ----------------------------------------------------------------------------
// hdfd_pkg
// Types, code table and match function of the prefix-code frame decoder.
// ----------------------------------------------------------------------------
package hdfd_pkg;

  localparam int FRAME_BITS_DEF = 64;
  localparam int NUM_CODES      = 46;
  localparam int HEAD_W         = 12;

  localparam logic [6:0] EOT_CHAR   = 7'h04;
  localparam logic [6:0] SPACE_CHAR = 7'h20;

  typedef struct packed {
    logic [63:0] frame_word;
    logic [4:0]  pad_bits;
  } in_t;

  typedef struct packed {
    logic [6:0] char_code;
    logic       char_valid;
    logic       last_of_frame;
    logic       status;
  } out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FLUSH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic step;
    logic flush;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic data_flag;
    logic hit;
    logic terminal;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] len;
    logic [6:0] ch;
  } match_t;

  localparam logic [11:0] CODE_TAB [NUM_CODES] = '{
    12'h000, 12'h001,
    12'h00C, 12'h00A, 12'h007, 12'h005, 12'h004,
    12'h01F, 12'h01E, 12'h01D, 12'h017, 12'h016,
    12'h039, 12'h038, 12'h037, 12'h036, 12'h034, 12'h027, 12'h026, 12'h01A,
    12'h019, 12'h018,
    12'h037, 12'h040, 12'h041, 12'h042, 12'h043, 12'h044, 12'h045, 12'h046,
    12'h047, 12'h048, 12'h049, 12'h04A, 12'h04B, 12'h06A, 12'h036,
    12'h0D7,
    12'h35A, 12'h359,
    12'h6B6, 12'h6B0,
    12'hD63, 12'hD6E, 12'hD6F, 12'hD62
  };

  localparam logic [3:0] LEN_TAB [NUM_CODES] = '{
    4'd3, 4'd3,
    4'd4, 4'd4, 4'd4, 4'd4, 4'd4,
    4'd5, 4'd5, 4'd5, 4'd5, 4'd5,
    4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6, 4'd6,
    4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7, 4'd7,
    4'd7, 4'd7, 4'd7,
    4'd8,
    4'd10, 4'd10,
    4'd11, 4'd11,
    4'd12, 4'd12, 4'd12, 4'd12
  };

  localparam logic [6:0] CHAR_TAB [NUM_CODES] = '{
    7'h20, 7'h45,
    7'h54, 7'h41, 7'h4F, 7'h49, 7'h4E,
    7'h53, 7'h48, 7'h52, 7'h44, 7'h4C,
    7'h43, 7'h55, 7'h4D, 7'h57, 7'h46, 7'h47, 7'h51, 7'h59, 7'h50, 7'h42,
    7'h21, 7'h2E, 7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
    7'h38, 7'h39, 7'h3F, 7'h5E, 7'h56,
    7'h4B,
    7'h4A, 7'h58,
    7'h5A, 7'h3A,
    7'h2B, 7'h2D, 7'h2F, EOT_CHAR
  };

  // Match the head of the window against every code; the lowest table index wins.
  function automatic match_t hdfd_match(input logic [HEAD_W-1:0] head,
                                        input logic [3:0] avail);
    match_t m;
    m = '0;
    for (int i = NUM_CODES - 1; i >= 0; i--) begin
      if ((LEN_TAB[i] <= avail) &&
          ((head >> (4'd12 - LEN_TAB[i])) == CODE_TAB[i])) begin
        m.hit = 1'b1;
        m.len = LEN_TAB[i];
        m.ch  = CHAR_TAB[i];
      end
    end
    return m;
  endfunction

endpackage

FILE: rtl/core/huffman_data_frame_decoder_top.sv
// ----------------------------------------------------------------------------
// huffman_data_frame_decoder_top
// Static prefix-code text decoder for one data frame per input beat.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) takes one frame beat:
//   the frame word and its pad count. in_ready_o is high only between frames.
//   Output channel (out_valid_o / out_ready_i / out_data_o) gives one beat per
//   decoded character, the final one marked last_of_frame. A frame whose data
//   flag is clear, or that decodes to nothing, gives a single beat with
//   char_valid low.
//   Timing: the frame is loaded first, then the matcher consumes one code per
//   cycle while the output is free; each character waits in the hold stage so
//   that it can be marked last when the next match fails or the frame ends.
//   A new frame is accepted while the last beat of the previous one waits.
//   Stall: when out_ready_i is low with a beat pending, decoding holds and
//   the pending beat stays unchanged until taken.
//   Reset: rst_ni clears the sequencer and the output valid, so a pending beat
//   is dropped and none is invented; the block comes up ready.
// ----------------------------------------------------------------------------
`include "huffman_data_frame_decoder_top_defines.svh"

module huffman_data_frame_decoder_top
  import hdfd_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
)(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // Sequencer: decides when to load, step the matcher and close the frame.
  hdfd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Datapath: bit window, matcher, hold stage and output register.
  hdfd_dpath #(
    .FRAME_BITS (FRAME_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

  // Non-data frames close without decoding, with one invalid, last beat.
  `HDFD_ASSERT_IMP(a_status_beat, out_valid_o && out_data_o.status, !out_data_o.char_valid && out_data_o.last_of_frame, "non-data beat malformed")
  // An empty character slot only ever closes a frame.
  `HDFD_ASSERT_IMP(a_invalid_last, out_valid_o && !out_data_o.char_valid, out_data_o.last_of_frame, "invalid character not marked last")
  // Accepting a frame always leaves the block busy in the next cycle.
  `HDFD_ASSERT_NXT(a_busy_after_load, in_valid_i && in_ready_o, !in_ready_o, "ready right after frame accept")
  // Beats are only emitted while a frame is open, never in the load cycle.
  `HDFD_ASSERT_IMP(a_no_emit_on_load, cmd.load, !cmd.step && !cmd.flush, "emit during frame load")

endmodule

FILE: rtl/core/hdfd_ctrl.sv
// ----------------------------------------------------------------------------
// hdfd_ctrl
// Frame sequencer: load, one code per cycle while the output is free, then a closing beat.
// ----------------------------------------------------------------------------
module hdfd_ctrl
  import hdfd_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sts_i.data_flag ? ST_DECODE : ST_FLUSH;
        end
      end
      ST_DECODE: begin
        if (!sts_i.hit) begin
          state_d = ST_FLUSH;
        end else if (sts_i.out_free) begin
          cmd_o.step = 1'b1;
          if (sts_i.terminal) begin
            state_d = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        if (sts_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/hdfd_dpath.sv
// ----------------------------------------------------------------------------
// hdfd_dpath
// Bit window, code matcher, one-character hold stage and output register.
// ----------------------------------------------------------------------------
module hdfd_dpath
  import hdfd_pkg::*;
#(
  parameter int FRAME_BITS = FRAME_BITS_DEF
)(
  input  logic clk_i,
  input  logic rst_ni,
  input  in_t  in_data_i,
  output out_t out_data_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  cmd_t cmd_i,
  output sts_t sts_o
);

  localparam int PB = FRAME_BITS - 1;
  localparam int CW = $clog2(FRAME_BITS);
  localparam logic [5:0] PB6 = 6'(PB);

  logic [PB-1:0] window_q, window_d;
  logic [CW-1:0] left_q, left_d;
  logic          status_q;
  logic [6:0]    hold_q;
  logic          hv_q;
  out_t          out_q;
  logic          ov_q;

  logic [PB-1:0] payload;
  logic [3:0]    avail;
  match_t        m;
  logic [6:0]    ch_map;
  logic          emit;
  out_t          emit_data;

  assign payload = in_data_i.frame_word[PB-1:0];
  assign avail   = (left_q >= CW'(HEAD_W)) ? 4'(HEAD_W) : 4'(left_q);
  assign m       = hdfd_match(window_q[PB-1 -: HEAD_W], avail);
  assign ch_map  = (m.ch == EOT_CHAR) ? SPACE_CHAR : m.ch;

  assign sts_o.data_flag = in_data_i.frame_word[FRAME_BITS-1];
  assign sts_o.hit       = m.hit;
  assign sts_o.terminal  = (left_q == CW'(m.len)) || (m.ch == EOT_CHAR);
  assign sts_o.out_free  = !ov_q || out_ready_i;

  // Window: left aligned, next code bit at the top; pad bits sit below left_q.
  always_comb begin
    window_d = window_q;
    left_d   = left_q;
    if (cmd_i.load) begin
      if ({1'b0, in_data_i.pad_bits} >= PB6) begin
        window_d = '0;
        left_d   = '0;
      end else begin
        window_d = payload;
        left_d   = CW'(PB6 - {1'b0, in_data_i.pad_bits});
      end
    end else if (cmd_i.step) begin
      window_d = window_q << m.len;
      left_d   = left_q - CW'(m.len);
    end
  end

  always_comb begin
    emit      = (cmd_i.step && hv_q) || cmd_i.flush;
    emit_data = '0;
    if (cmd_i.flush) begin
      emit_data.char_code     = hv_q ? hold_q : 7'd0;
      emit_data.char_valid    = hv_q;
      emit_data.last_of_frame = 1'b1;
      emit_data.status        = status_q;
    end else begin
      emit_data.char_code  = hold_q;
      emit_data.char_valid = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    window_q <= window_d;
    if (cmd_i.load) begin
      status_q <= !in_data_i.frame_word[FRAME_BITS-1];
    end
    if (cmd_i.step) begin
      hold_q <= ch_map;
    end
    if (emit) begin
      out_q <= emit_data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      hv_q   <= 1'b0;
      ov_q   <= 1'b0;
    end else begin
      left_q <= left_d;
      if (cmd_i.load || cmd_i.flush) begin
        hv_q <= 1'b0;
      end else if (cmd_i.step) begin
        hv_q <= 1'b1;
      end
      if (emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  assign out_data_o  = out_q;
  assign out_valid_o = ov_q;

endmodule
